// ===== src/grid_multisource_bfs_depth_unit_macros.svh =====
// assertion macros for the grid spread depth unit
// expects clock and reset in the scope of each use
`ifndef GRID_MULTISOURCE_BFS_DEPTH_UNIT_MACROS_SVH
`define GRID_MULTISOURCE_BFS_DEPTH_UNIT_MACROS_SVH

// same-cycle implication
`define GMBFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gmbfs: same-cycle check failed");

// next-cycle implication
`define GMBFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gmbfs: next-cycle check failed");

`endif

// ===== src/gmbfs_pkg.sv =====
// shared types, codes and defaults for the grid spread depth unit
// no dependencies
package gmbfs_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 12;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;

   localparam logic [1:0] CELL_TARGET = 2'd1;
   localparam logic [1:0] CELL_SOURCE = 2'd2;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic [STEP_W-1:0] LEVEL_MAX = '1;

   typedef struct packed {
      logic [1:0] cell_state;
      logic       last_cell;
   } req_type;

   typedef struct packed {
      logic [STEP_W-1:0] steps_taken;
      logic              unreachable;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
   } dims_type;

endpackage

// ===== src/gmbfs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module gmbfs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gmbfs_div.sv =====
// restoring divider, one quotient bit a cycle: cell index to row and column
// uses gmbfs_pkg
module gmbfs_div #(
   parameter int AW = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [AW-1:0]               dividend,
   input  logic [gmbfs_pkg::DIM_W-1:0] divisor,
   output logic                        done,
   output logic [AW-1:0]               quotient,
   output logic [gmbfs_pkg::DIM_W-1:0] remainder
);

   localparam int DW   = gmbfs_pkg::DIM_W;
   localparam int CNTW = $clog2(AW + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW:0]     trial;
   logic [DW:0]     diff;
   logic            ge;
   logic [AW-1:0]   quo_shift;

   always_comb begin
      trial     = {rem_ff, quo_ff[AW-1]};
      ge        = trial >= {1'b0, divisor};
      diff      = trial - {1'b0, divisor};
      quo_shift = quo_ff << 1;
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = CNTW'(AW);
         quo_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         quo_in = quo_shift | AW'(ge);
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/gmbfs_ctrl.sv =====
// sequencer: grid load, level-by-level spread over the cell and queue rams, result
// uses gmbfs_pkg; drives gmbfs_ram and gmbfs_div ports from the top level
module gmbfs_ctrl #(
   parameter int MAX_ROWS = gmbfs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmbfs_pkg::DEF_MAX_COLS
) (
   input  logic                                                        clock,
   input  logic                                                        reset,
   input  logic                                                        start,
   output logic                                                        busy,
   input  gmbfs_pkg::req_type                                          req_item,
   output logic                                                        rsp_valid,
   output gmbfs_pkg::rsp_type                                          rsp_item,
   input  gmbfs_pkg::dims_type                                         dims,
   output logic                                                        st_we,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] st_waddr,
   output logic [1:0]                                                  st_wdata,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] st_raddr,
   input  logic [1:0]                                                  st_rdata,
   output logic                                                        q_we,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] q_waddr,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] q_wdata,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] q_raddr,
   input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] q_rdata,
   output logic                                                        div_go,
   output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] div_dividend,
   input  logic                                                        div_done,
   input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] div_quo,
   input  logic [gmbfs_pkg::DIM_W-1:0]                                 div_rem
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DW    = gmbfs_pkg::DIM_W;
   localparam int SW    = gmbfs_pkg::STEP_W;
   localparam int NW    = ((CW > 2 * DW) ? CW : 2 * DW) + 1;

   typedef enum logic [2:0] {
      S_LOAD,
      S_LEVEL,
      S_QREAD,
      S_QWAIT,
      S_DIV,
      S_NB,
      S_NBCHK
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      load_ff, load_in;
   logic [CW-1:0]      head_ff, head_in;
   logic [CW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      fresh_ff, fresh_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic [SW-1:0]      level_ff, level_in;
   logic               prog_ff, prog_in;
   logic [1:0]         dir_ff, dir_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gmbfs_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic [2*DW-1:0] total;
   logic [NW-1:0]   limit_n;
   logic [NW-1:0]   load_n;
   logic [NW-1:0]   rows_n;
   logic [NW-1:0]   cols_n;
   logic [NW-1:0]   pos_n;
   logic [NW-1:0]   r_n;
   logic [NW-1:0]   c_n;
   logic [NW-1:0]   nb_idx;
   logic            nb_ok;
   logic            nb_hit;
   logic            accept;
   logic            room;
   logic            mark;
   logic            adv;
   logic            prog_now;

   assign busy   = state_ff != S_LOAD;
   assign accept = start && !busy;

   always_comb begin
      total   = dims.rows * dims.cols;
      limit_n = (NW'(total) < NW'(DEPTH)) ? NW'(total) : NW'(DEPTH);
      load_n  = NW'(load_ff);
      room    = load_n < limit_n;
      rows_n  = NW'(dims.rows);
      cols_n  = NW'(dims.cols);
      pos_n   = NW'(pos_ff);
      r_n     = NW'(div_quo);
      c_n     = NW'(div_rem);
   end

   // neighbour in direction order down, up, right, left
   always_comb begin
      unique case (dir_ff)
         gmbfs_pkg::DIR_DOWN: begin
            nb_ok  = (r_n + NW'(1)) < rows_n;
            nb_idx = pos_n + cols_n;
         end
         gmbfs_pkg::DIR_UP: begin
            nb_ok  = r_n != '0;
            nb_idx = pos_n - cols_n;
         end
         gmbfs_pkg::DIR_RIGHT: begin
            nb_ok  = (c_n + NW'(1)) < cols_n;
            nb_idx = pos_n + NW'(1);
         end
         default: begin
            nb_ok  = c_n != '0;
            nb_idx = pos_n - NW'(1);
         end
      endcase
      nb_hit = nb_ok && (nb_idx < load_n);
   end

   assign mark     = (state_ff == S_NBCHK) && (st_rdata == gmbfs_pkg::CELL_TARGET);
   assign prog_now = prog_ff || mark;

   // ram and divider ports
   always_comb begin
      st_we        = (accept && room) || mark;
      st_waddr     = (state_ff == S_NBCHK) ? idx_ff : load_ff[AW-1:0];
      st_wdata     = (state_ff == S_NBCHK) ? gmbfs_pkg::CELL_SOURCE : req_item.cell_state;
      st_raddr     = nb_idx[AW-1:0];
      q_we         = (accept && room && (req_item.cell_state == gmbfs_pkg::CELL_SOURCE))
                     || mark;
      q_waddr      = tail_ff[AW-1:0];
      q_wdata      = (state_ff == S_NBCHK) ? idx_ff : load_ff[AW-1:0];
      q_raddr      = head_ff[AW-1:0];
      div_go       = state_ff == S_QWAIT;
      div_dividend = q_rdata;
   end

   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fresh_in     = fresh_ff;
      remain_in    = remain_ff;
      level_in     = level_ff;
      prog_in      = prog_ff;
      dir_in       = dir_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      adv          = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (room) begin
                  load_in = load_ff + CW'(1);
                  if (req_item.cell_state == gmbfs_pkg::CELL_TARGET) begin
                     fresh_in = fresh_ff + CW'(1);
                  end else if (req_item.cell_state == gmbfs_pkg::CELL_SOURCE) begin
                     tail_in = tail_ff + CW'(1);
                  end
               end
               if (req_item.last_cell) begin
                  state_in = S_LEVEL;
               end
            end
         end
         S_LEVEL: begin
            if ((head_ff < tail_ff) && (fresh_ff != '0)) begin
               remain_in = tail_ff - head_ff;
               prog_in   = 1'b0;
               state_in  = S_QREAD;
            end else begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.steps_taken = (fresh_ff == '0) ? level_ff : '0;
               rsp_item_in.unreachable = fresh_ff != '0;
               load_in   = '0;
               head_in   = '0;
               tail_in   = '0;
               fresh_in  = '0;
               remain_in = '0;
               level_in  = '0;
               prog_in   = 1'b0;
               state_in  = S_LOAD;
            end
         end
         S_QREAD: begin
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            pos_in    = q_rdata;
            head_in   = head_ff + CW'(1);
            remain_in = remain_ff - CW'(1);
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               dir_in   = gmbfs_pkg::DIR_DOWN;
               state_in = S_NB;
            end
         end
         S_NB: begin
            if (nb_hit) begin
               idx_in   = nb_idx[AW-1:0];
               state_in = S_NBCHK;
            end else begin
               adv = 1'b1;
            end
         end
         S_NBCHK: begin
            if (mark) begin
               tail_in  = tail_ff + CW'(1);
               fresh_in = fresh_ff - CW'(1);
               prog_in  = 1'b1;
            end
            adv = 1'b1;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // next neighbour, next queued cell or end of level
      if (adv) begin
         if (dir_ff != gmbfs_pkg::DIR_LEFT) begin
            dir_in   = dir_ff + 2'd1;
            state_in = S_NB;
         end else if (remain_ff != '0) begin
            state_in = S_QREAD;
         end else begin
            if (prog_now && (level_ff != gmbfs_pkg::LEVEL_MAX)) begin
               level_in = level_ff + SW'(1);
            end
            state_in = S_LEVEL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fresh_ff     <= '0;
         remain_ff    <= '0;
         level_ff     <= '0;
         prog_ff      <= 1'b0;
         dir_ff       <= gmbfs_pkg::DIR_DOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fresh_ff     <= fresh_in;
         remain_ff    <= remain_in;
         level_ff     <= level_in;
         prog_ff      <= prog_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== src/grid_multisource_bfs_depth_unit.sv =====
// top level of the grid spread depth unit: size registers, rams, divider, sequencer
// uses gmbfs_pkg, gmbfs_ram, gmbfs_div, gmbfs_ctrl
//
//   channel   handshake          payload
//   request   start / busy       req_item  (cell_state, last_cell)
//   response  rsp_valid strobe   rsp_item  (steps_taken, unreachable)
//   csr       csr_we             csr_index, csr_wdata
//
// a cell is taken whenever start is high and busy is low; busy stays low until the cell
// marked last_cell; after the last cell, each queued cell takes a queue read, a bit-serial
// divide of its index by the column count and a check of each neighbour, plus a level
// step per level and one for the result; rsp_valid pulses in the cycle busy falls
// reset is synchronous; no clearing pass, the rams are only read where written
// the receiver cannot stall: a result is shown for exactly one cycle
module grid_multisource_bfs_depth_unit #(
   parameter int MAX_ROWS = gmbfs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = gmbfs_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gmbfs_pkg::req_type              req_item,
   output logic                            rsp_valid,
   output gmbfs_pkg::rsp_type              rsp_item,
   input  logic                            csr_we,
   input  logic [gmbfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmbfs_pkg::DIM_W-1:0]     csr_wdata
);

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW      = gmbfs_pkg::DIM_W;
   localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
   localparam logic [DW-1:0] ROW_TOP = DW'(ROW_LIM);
   localparam logic [DW-1:0] COL_TOP = DW'(COL_LIM);
   localparam logic [DW-1:0] ROW_RST = (ROW_LIM < 64) ? DW'(ROW_LIM) : gmbfs_pkg::DIM_RESET;
   localparam logic [DW-1:0] COL_RST = (COL_LIM < 64) ? DW'(COL_LIM) : gmbfs_pkg::DIM_RESET;

   logic [DW-1:0]       rows_ff, rows_in;
   logic [DW-1:0]       cols_ff, cols_in;
   logic [DW-1:0]       row_new;
   logic [DW-1:0]       col_new;
   gmbfs_pkg::dims_type dims;

   logic          st_we;
   logic [AW-1:0] st_waddr;
   logic [1:0]    st_wdata;
   logic [AW-1:0] st_raddr;
   logic [1:0]    st_rdata;
   logic          q_we;
   logic [AW-1:0] q_waddr;
   logic [AW-1:0] q_wdata;
   logic [AW-1:0] q_raddr;
   logic [AW-1:0] q_rdata;
   logic          div_go;
   logic [AW-1:0] div_dividend;
   logic          div_done;
   logic [AW-1:0] div_quo;
   logic [DW-1:0] div_rem;

   // sizes are clamped on write to 1..maximum
   always_comb begin
      row_new = (csr_wdata == '0) ? DW'(1) : ((csr_wdata > ROW_TOP) ? ROW_TOP : csr_wdata);
      col_new = (csr_wdata == '0) ? DW'(1) : ((csr_wdata > COL_TOP) ? COL_TOP : csr_wdata);
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            gmbfs_pkg::CSR_ROW_COUNT: rows_in = row_new;
            gmbfs_pkg::CSR_COL_COUNT: cols_in = col_new;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROW_RST;
         cols_ff <= COL_RST;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign dims.rows = rows_ff;
   assign dims.cols = cols_ff;

   gmbfs_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   gmbfs_ram #(
      .WIDTH (AW),
      .DEPTH (DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   gmbfs_div #(
      .AW (AW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_dividend),
      .divisor   (cols_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   gmbfs_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .dims         (dims),
      .st_we        (st_we),
      .st_waddr     (st_waddr),
      .st_wdata     (st_wdata),
      .st_raddr     (st_raddr),
      .st_rdata     (st_rdata),
      .q_we         (q_we),
      .q_waddr      (q_waddr),
      .q_wdata      (q_wdata),
      .q_raddr      (q_raddr),
      .q_rdata      (q_rdata),
      .div_go       (div_go),
      .div_dividend (div_dividend),
      .div_done     (div_done),
      .div_quo      (div_quo),
      .div_rem      (div_rem)
   );

endmodule

// ===== src/gmbfs_chk.sv =====
// port-level checks for the grid spread depth unit, bound to the top level
// uses gmbfs_pkg and grid_multisource_bfs_depth_unit_macros.svh
`include "grid_multisource_bfs_depth_unit_macros.svh"

module gmbfs_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input gmbfs_pkg::req_type req_item,
   input logic               rsp_valid,
   input gmbfs_pkg::rsp_type rsp_item
);

   `GMBFS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `GMBFS_ASSERT_NOW(a_unreach_zero, rsp_valid && rsp_item.unreachable, rsp_item.steps_taken == '0)
   `GMBFS_ASSERT_NEXT(a_last_busy, start && !busy && req_item.last_cell, busy)
   `GMBFS_ASSERT_NEXT(a_cell_quiet, start && !busy && !req_item.last_cell, !busy && !rsp_valid)
   `GMBFS_ASSERT_NOW(a_end_result, $fell(busy), rsp_valid)

endmodule

bind grid_multisource_bfs_depth_unit gmbfs_chk u_chk (.*);
